FILE: rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg - wildcard pattern matcher shared definitions
// Request modes, wildcard codes, default sizes and the cell link types.
// ----------------------------------------------------------------------------
package wpm_pkg;

    // default sizes handed to the top level
    localparam int PATTERN_MAX_DEF = 32;
    localparam int CHAR_BITS_DEF   = 16;

    // fixed width of the character field on the request port
    localparam int CHAR_CODE_W = 16;

    // wildcard codes
    localparam int CODE_STAR  = 42;
    localparam int CODE_QMARK = 63;

    // request modes
    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SUBJECT = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    // per-request strobes broadcast to every cell
    typedef struct packed {
        logic clear;
        logic append;
        logic advance;
        logic rearm;
    } wpm_ctrl_t;

    // signals handed from one cell to its right neighbor
    typedef struct packed {
        logic occ;    // left position holds a pattern char
        logic grow;   // start-set extends to this position
        logic shift;  // left position consumed the subject char
        logic close;  // wildcard closure carried from the left
    } wpm_link_t;

endpackage

FILE: rtl/core/wildcard_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_top - glob matcher on a chain of position cells
// Star matches any run, question mark matches zero or one char.
// ----------------------------------------------------------------------------
// Usage:
//   One request channel (s_valid/s_ready, s_mode, s_char_code) and one
//   result channel (m_valid/m_ready, m_matched, m_pattern_overflow).
//   A request is clear pattern, append pattern char, subject char or end of
//   subject. Only end of subject produces a result, in the cycle after it is
//   taken; the result stays registered until the receiver takes it.
//   Throughput is one request per cycle: every cell of the chain updates its
//   position in the same cycle, the wildcard closure rippling through the
//   chain like a carry. Pattern chars go to the first free cell.
//   While a result waits, clear, append and subject requests are still taken;
//   a second end of subject waits until the pending result is taken.
//   A pattern longer than PATTERN_MAX sets the overflow flag until the next
//   clear and forces no match.
//   Reset leaves an empty pattern, overflow clear and no result pending.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_top #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF,
    parameter int CHAR_BITS   = wpm_pkg::CHAR_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_mode,
    input  logic [wpm_pkg::CHAR_CODE_W-1:0]  s_char_code,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_matched,
    output logic                             m_pattern_overflow
);
    import wpm_pkg::*;

    mode_t                mode;
    logic                 in_acc;
    logic [CHAR_BITS-1:0] cdata;
    wpm_ctrl_t            ctrl;
    wpm_link_t            link [PATTERN_MAX:0];
    logic [PATTERN_MAX:0] hits;
    logic [PATTERN_MAX-1:0] occ_vec;
    logic [PATTERN_MAX-1:0] prv_vec;

    logic arm_last_reg, arm_last_next;
    logic act_last_reg, act_last_next;
    logic ovf_reg, ovf_next;
    logic m_valid_reg, m_valid_next;
    logic m_matched_reg;
    logic m_overflow_reg;

    // request decode
    assign mode    = mode_t'(s_mode);
    assign s_ready = ~m_valid_reg | m_ready | (mode != MODE_END);
    assign in_acc  = s_valid & s_ready;
    assign cdata   = CHAR_BITS'(s_char_code);

    assign ctrl.clear   = in_acc & (mode == MODE_CLEAR);
    assign ctrl.append  = in_acc & (mode == MODE_APPEND);
    assign ctrl.advance = in_acc & (mode == MODE_SUBJECT);
    assign ctrl.rearm   = in_acc & (mode == MODE_END);

    // head of the chain: position zero always in the start set
    assign link[0] = '{occ: 1'b1, grow: 1'b1, shift: 1'b0, close: 1'b0};

    // chain of position cells
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        wpm_cell #(
            .CHAR_BITS (CHAR_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .cdata    (cdata),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .hit      (hits[i])
        );
        assign occ_vec[i] = link[i+1].occ;
        assign prv_vec[i] = link[i].occ;
    end

    // final position, reached only by a full store
    always_comb begin
        if (ctrl.clear) begin
            arm_last_next = 1'b0;
        end else begin
            arm_last_next = arm_last_reg | (ctrl.append & link[PATTERN_MAX].grow);
        end
    end

    always_comb begin
        if (ctrl.clear || ctrl.append || ctrl.rearm) begin
            act_last_next = arm_last_next;
        end else if (ctrl.advance) begin
            act_last_next = link[PATTERN_MAX].shift | link[PATTERN_MAX].close;
        end else begin
            act_last_next = act_last_reg;
        end
    end

    assign hits[PATTERN_MAX] = act_last_reg;

    // overflow flag: append into a full store
    always_comb begin
        if (ctrl.clear) begin
            ovf_next = 1'b0;
        end else if (ctrl.append && link[PATTERN_MAX].occ) begin
            ovf_next = 1'b1;
        end else begin
            ovf_next = ovf_reg;
        end
    end

    // result register
    always_comb begin
        if (ctrl.rearm) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_last_reg <= 1'b0;
            act_last_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            arm_last_reg <= arm_last_next;
            act_last_reg <= act_last_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (ctrl.rearm) begin
            m_matched_reg  <= (|hits) & ~ovf_reg;
            m_overflow_reg <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_overflow_reg;

`ifndef SYNTH
    // pattern chars fill the chain from the left without gaps
    a_occ_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_vec & ~prv_vec) == '0)
        else $error("pattern occupancy has a gap");

    // only the end-of-pattern position can report a hit
    a_hit_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hits))
        else $error("more than one end-of-pattern hit");

    // clear empties the store and drops the overflow flag
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> (occ_vec == '0) && !ovf_reg)
        else $error("clear left pattern state behind");

    // every end of subject produces a pending result
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rearm |=> m_valid_reg)
        else $error("end of subject without a result");

    // overflow forces no match
    a_ovf_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_matched_reg && m_overflow_reg))
        else $error("match reported with overflow");
`endif

endmodule

FILE: rtl/core/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell - one pattern position of the matcher chain
// Holds one pattern char, its start-set bit and its active bit, and passes
// occupancy, start-set growth, consumed-char and closure signals rightward.
// ----------------------------------------------------------------------------
module wpm_cell #(
    parameter int CHAR_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wpm_pkg::wpm_ctrl_t   ctrl,
    input  logic [CHAR_BITS-1:0] cdata,
    input  wpm_pkg::wpm_link_t   link_in,
    output wpm_pkg::wpm_link_t   link_out,
    output logic                 hit
);
    import wpm_pkg::*;

    logic [CHAR_BITS-1:0] char_reg, char_next;
    logic                 star_reg, star_next;
    logic                 qmark_reg, qmark_next;
    logic                 occ_reg, occ_next;
    logic                 arm_reg, arm_next;
    logic                 act_reg, act_next;

    logic target;
    logic c_star;
    logic c_qmark;
    logic nxt_fin;

    // this cell takes the next appended char
    assign target  = ~occ_reg & link_in.occ;
    assign c_star  = (cdata == CHAR_BITS'(CODE_STAR));
    assign c_qmark = (cdata == CHAR_BITS'(CODE_QMARK));

    // pattern char load
    always_comb begin
        char_next  = char_reg;
        star_next  = star_reg;
        qmark_next = qmark_reg;
        occ_next   = occ_reg;
        if (ctrl.clear) begin
            occ_next = 1'b0;
        end else if (ctrl.append && target) begin
            char_next  = cdata;
            star_next  = c_star;
            qmark_next = c_qmark;
            occ_next   = 1'b1;
        end
    end

    // start set: position reachable through wildcards only
    always_comb begin
        if (ctrl.clear) begin
            arm_next = link_in.grow;
        end else begin
            arm_next = arm_reg | (ctrl.append & link_in.grow);
        end
    end

    // automaton step for one subject char
    assign nxt_fin = link_in.shift | (act_reg & occ_reg & star_reg) | link_in.close;

    always_comb begin
        if (ctrl.clear || ctrl.append || ctrl.rearm) begin
            act_next = arm_next;
        end else if (ctrl.advance) begin
            act_next = nxt_fin;
        end else begin
            act_next = act_reg;
        end
    end

    // links to the right neighbor
    assign link_out.occ   = occ_reg;
    assign link_out.grow  = ctrl.append & target & arm_reg & (c_star | c_qmark);
    assign link_out.shift = act_reg & occ_reg & ~star_reg
                          & (qmark_reg | (char_reg == cdata));
    assign link_out.close = nxt_fin & occ_reg & (star_reg | qmark_reg);

    // active at the end of the pattern
    assign hit = act_reg & ~occ_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            arm_reg <= link_in.grow;
            act_reg <= link_in.grow;
        end else begin
            occ_reg <= occ_next;
            arm_reg <= arm_next;
            act_reg <= act_next;
        end
    end

    // pattern char storage
    always_ff @(posedge aclk) begin
        char_reg  <= char_next;
        star_reg  <= star_next;
        qmark_reg <= qmark_next;
    end

endmodule

FILE: verif/tb_wildcard_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// tb_wildcard_pattern_matcher_top - glob matcher self-checking bench
// Pattern loads and subject streams go in through the request channel. A
// bit-vector glob predictor inside the bench computes every end-of-subject
// verdict, and each returned result is compared with the oldest prediction.
// Directed cases come first. They cover the empty pattern, the extreme codes,
// both wildcards, an append in mid-subject and an overflowing pattern. A
// long result stall follows, and the run ends with random sessions, with
// random gaps on both channels except during bursts.
// ----------------------------------------------------------------------------
module tb_wildcard_pattern_matcher_top;
    import wpm_pkg::*;

    localparam int PMAX        = PATTERN_MAX_DEF;
    localparam int CW          = CHAR_BITS_DEF;
    localparam int RANDOM_REQS = 1600;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic matched;
        logic overflow;
    } glob_verdict_t;

    logic            aclk               = 1'b0;
    logic            aresetn            = 1'b0;
    logic            s_valid            = 1'b0;
    logic            s_ready;
    logic [1:0]      s_mode             = MODE_CLEAR;
    logic [CW-1:0]   s_char_code        = '0;
    logic            m_valid;
    logic            m_ready            = 1'b0;
    logic            m_matched;
    logic            m_pattern_overflow;

    // glob predictor state
    logic [CW-1:0]   pat_mem [PMAX];
    int unsigned     pat_len            = 0;
    logic            pat_ovf            = 1'b0;
    logic [PMAX:0]   live               = (PMAX+1)'(1);
    glob_verdict_t   verdict_q [$];

    int unsigned     requests_taken     = 0;
    int unsigned     mismatch_count     = 0;
    int unsigned     cycle_count        = 0;
    bit              tx_burst           = 1'b0;
    bit              rx_burst           = 1'b0;
    int              rx_hold            = 0;
    int              rx_stall           = 0;

    wildcard_pattern_matcher_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_char_code        (s_char_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // wildcard closure: a live wildcard position also makes the next one live
    function automatic logic [PMAX:0] glob_close(logic [PMAX:0] set);
        for (int i = 0; i < pat_len; i++) begin
            if (set[i] && (pat_mem[i] == CW'(CODE_STAR) || pat_mem[i] == CW'(CODE_QMARK)))
                set[i+1] = 1'b1;
        end
        return set;
    endfunction

    function automatic logic [PMAX:0] glob_armed();
        logic [PMAX:0] set;
        set = '0;
        set[0] = 1'b1;
        return glob_close(set);
    endfunction

    // one subject char through the live set
    function automatic logic [PMAX:0] glob_advance(logic [CW-1:0] ch);
        logic [PMAX:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
            if (live[i]) begin
                if (pat_mem[i] == CW'(CODE_STAR))
                    nxt[i] = 1'b1;
                else if (pat_mem[i] == CW'(CODE_QMARK) || pat_mem[i] == ch)
                    nxt[i+1] = 1'b1;
            end
        end
        return glob_close(nxt);
    endfunction

    // predictor update for one accepted request
    task automatic glob_step(input mode_t md, input logic [CW-1:0] ch);
        glob_verdict_t v;
        case (md)
            MODE_CLEAR: begin
                pat_len = 0;
                pat_ovf = 1'b0;
                live    = glob_armed();
            end
            MODE_APPEND: begin
                if (pat_len < PMAX) begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                live = glob_armed();
            end
            MODE_SUBJECT: begin
                live = glob_advance(ch);
            end
            default: begin
                v.matched  = live[pat_len] && !pat_ovf;
                v.overflow = pat_ovf;
                verdict_q.push_back(v);
                live = glob_armed();
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // idle lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // subject chars: a small alphabet so that literals hit, plus extremes
    function automatic logic [CW-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CW'("a");
        if (r < 55)
            return CW'("b");
        if (r < 65)
            return CW'("c");
        if (r < 70)
            return '0;
        if (r < 75)
            return '1;
        return CW'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CW-1:0] pick_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CW'(CODE_STAR);
        if (r < 40)
            return CW'(CODE_QMARK);
        return pick_char();
    endfunction

    // result checker
    always @(posedge aclk) begin
        glob_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with no end of subject pending");
            end else begin
                want = verdict_q.pop_front();
                if (m_matched !== want.matched)
                    report_mismatch($sformatf("matched %b, expected %b",
                                              m_matched, want.matched));
                if (m_pattern_overflow !== want.overflow)
                    report_mismatch($sformatf("pattern_overflow %b, expected %b",
                                              m_pattern_overflow, want.overflow));
            end
        end
    end

    // result receiver: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_burst && $urandom_range(0, 99) < 25)
                rx_stall = pick_gap();
        end
    end

    // one request; entered and left at a falling edge
    task automatic send_req(input mode_t md, input logic [CW-1:0] ch);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= md;
        s_char_code <= ch;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        glob_step(md, ch);
        requests_taken++;
        @(negedge aclk);
    endtask

    task automatic load_pattern(input string p);
        send_req(MODE_CLEAR, CW'($urandom_range(0, 65535)));
        for (int i = 0; i < p.len(); i++)
            send_req(MODE_APPEND, {8'h00, p[i]});
    endtask

    task automatic run_subject(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(MODE_SUBJECT, {8'h00, s[i]});
        send_req(MODE_END, CW'($urandom_range(0, 65535)));
    endtask

    // sender pause until every verdict is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge aclk);
    endtask

    // empty pattern matches only the empty subject
    task automatic test_empty_pattern();
        load_pattern("");
        run_subject("");
        run_subject("x");
        wait_drained();
    endtask

    // code zero and all-ones are plain literals
    task automatic test_extreme_codes();
        send_req(MODE_CLEAR, '1);
        send_req(MODE_APPEND, '0);
        send_req(MODE_APPEND, '1);
        send_req(MODE_SUBJECT, '0);
        send_req(MODE_SUBJECT, '1);
        send_req(MODE_END, '1);
        send_req(MODE_SUBJECT, '1);
        send_req(MODE_SUBJECT, '0);
        send_req(MODE_END, '0);
        wait_drained();
    endtask

    // star takes any run, question mark zero or one char
    task automatic test_wildcards();
        load_pattern("a*?b");
        run_subject("ab");
        run_subject("axyb");
        run_subject("ba");
        wait_drained();
    endtask

    // append while a subject is under way re-arms on the longer pattern
    task automatic test_append_mid_subject();
        load_pattern("ab");
        send_req(MODE_SUBJECT, CW'("a"));
        send_req(MODE_APPEND, CW'("c"));
        run_subject("abc");
        wait_drained();
    endtask

    // full store, then one char too many, then clear drops the flag
    task automatic test_pattern_overflow();
        send_req(MODE_CLEAR, '0);
        repeat (PMAX)
            send_req(MODE_APPEND, CW'(CODE_STAR));
        run_subject("ab");
        send_req(MODE_APPEND, CW'("q"));
        run_subject("ab");
        send_req(MODE_APPEND, CW'(CODE_QMARK));
        run_subject("");
        load_pattern("a");
        run_subject("a");
        wait_drained();
    endtask

    // long result stall: a second end of subject must block the input
    task automatic test_result_backpressure();
        load_pattern("a*");
        tx_burst = 1'b1;
        rx_hold  = 200;
        repeat (8) begin
            send_req(MODE_SUBJECT, CW'("a"));
            send_req(MODE_END, CW'($urandom_range(0, 65535)));
        end
        tx_burst = 1'b0;
        wait_drained();
    endtask

    // random sessions: mostly well-formed patterns and subjects built from them
    task automatic test_random_sessions(input int unsigned n_reqs);
        int unsigned   stop_at;
        logic [CW-1:0] pat [$];
        logic [CW-1:0] subj [$];
        int            plen;
        int            r;
        int            k;
        stop_at = requests_taken + n_reqs;
        while (requests_taken < stop_at) begin
            tx_burst = ($urandom_range(0, 9) < 2);
            rx_burst = ($urandom_range(0, 9) < 2);
            r = $urandom_range(0, 99);
            if (r < 85)
                plen = $urandom_range(0, 8);
            else if (r < 95)
                plen = $urandom_range(9, 31);
            else
                plen = $urandom_range(32, 36);
            // now and then keep appending onto the old pattern
            if ($urandom_range(0, 9) != 0)
                send_req(MODE_CLEAR, CW'($urandom_range(0, 65535)));
            pat.delete();
            repeat (plen) begin
                pat.push_back(pick_pattern_char());
                send_req(MODE_APPEND, pat[$]);
            end
            repeat ($urandom_range(1, 4)) begin
                // subject that follows the pattern, wildcards expanded at random
                subj.delete();
                foreach (pat[i]) begin
                    if (pat[i] == CW'(CODE_STAR))
                        repeat ($urandom_range(0, 3)) subj.push_back(pick_char());
                    else if (pat[i] == CW'(CODE_QMARK))
                        repeat ($urandom_range(0, 1)) subj.push_back(pick_char());
                    else
                        subj.push_back(pat[i]);
                end
                // broken subjects: one char dropped, changed or inserted
                if ($urandom_range(0, 99) < 25) begin
                    k = $urandom_range(0, subj.size());
                    r = $urandom_range(0, 2);
                    if (r == 0 && k < subj.size())
                        subj.delete(k);
                    else if (r == 1 && k < subj.size())
                        subj[k] = pick_char();
                    else
                        subj.insert(k, pick_char());
                end
                foreach (subj[i]) begin
                    if ($urandom_range(0, 99) < 3)
                        send_req(mode_t'($urandom_range(0, 3)), pick_pattern_char());
                    send_req(MODE_SUBJECT, subj[i]);
                end
                send_req(MODE_END, CW'($urandom_range(0, 65535)));
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // test sequence
    initial begin
        foreach (pat_mem[i])
            pat_mem[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_pattern();
        test_extreme_codes();
        test_wildcards();
        test_append_mid_subject();
        test_pattern_overflow();
        test_result_backpressure();
        test_random_sessions(RANDOM_REQS);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
